@@ rtl/pcpc_pkg.sv @@
// Package for the planar/chunky palette converter.
// Shared constants, controller/datapath command and status types.
// No dependencies.
package pcpc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW = 8;
  localparam int MAX_PLANES = 8;
  localparam int PLANE_W = 4;
  localparam int GROUP_PIXELS = 16;
  // Palette split into interleaved banks: entry = {row, bank}
  localparam int BANKS = 8;
  localparam int BANK_W = 3;
  localparam int BANK_ROWS = PALETTE_DEPTH / BANKS;
  localparam int ROW_W = 5;

  localparam logic ACT_PAL_WRITE = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  localparam logic CFG_TO_DEVICE = 1'b0;
  localparam logic CFG_PLANE_COUNT = 1'b1;

  typedef struct packed {
    logic             pal_write;   // write palette entry from input
    logic             load_plane;  // store plane word from input
    logic             search_start;
    logic             search_step;
    logic             merge_pen;   // OR found pen into plane words
    logic             rd_start;    // issue palette read for pixel
    logic [3:0]       emit_pos;
    logic             clear_group;
  } cmd_t;

  typedef struct packed {
    logic             search_done;
  } status_t;

endpackage

@@ rtl/pcpc_datapath.sv @@
// Datapath: palette memory, plane word store, pen search and pixel index.
// Depends on pcpc_pkg.
module pcpc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  pcpc_pkg::cmd_t       cmd,
  output pcpc_pkg::status_t    status,
  input  logic [7:0]           palette_index,
  input  logic [31:0]          data_word,
  input  logic [3:0]           planes,
  input  logic [3:0]           plane_sel,
  input  logic [3:0]           pixel_sel,
  output logic [31:0]          rd_data,
  output logic [15:0]          plane_word
);

  logic [pcpc_pkg::PALETTE_DEPTH-1:0] pal_valid;
  logic [15:0] plane_words [pcpc_pkg::MAX_PLANES];
  logic [pcpc_pkg::ROW_W:0]    scan_row;
  logic [pcpc_pkg::ROW_W-1:0]  cmp_row;
  logic        cmp_v;
  logic        found;
  logic [7:0]  pen;
  logic [31:0] key;
  logic        rd_en;
  logic [pcpc_pkg::ROW_W-1:0]  rd_addr;
  logic [pcpc_pkg::BANK_W-1:0] rd_bank;
  logic [31:0] bank_rd [pcpc_pkg::BANKS];
  logic        bank_hit;
  logic [pcpc_pkg::BANK_W-1:0] hit_bank;
  logic [7:0]  rd_idx;

  // Per-entry valid bits make never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (cmd.pal_write) begin
      pal_valid[palette_index] <= 1'b1;
    end
  end

  // Pixel index from plane bits, MSB leftmost
  always_comb begin
    rd_idx = '0;
    for (int p = 0; p < pcpc_pkg::MAX_PLANES; p++) begin
      if (4'(p) < planes) begin
        rd_idx[p] = plane_words[p][4'd15 - pixel_sel];
      end
    end
  end

  // One shared row address: pixel lookup or the next row of the scan
  assign rd_en   = cmd.rd_start || (cmd.search_step && !scan_row[pcpc_pkg::ROW_W]);
  assign rd_addr = cmd.rd_start ? rd_idx[7:3] : scan_row[pcpc_pkg::ROW_W-1:0];

  for (genvar b = 0; b < pcpc_pkg::BANKS; b++) begin : g_bank
    logic [31:0] mem [pcpc_pkg::BANK_ROWS];
    logic [31:0] q;
    logic        q_valid;

    always_ff @(posedge clk) begin
      if (cmd.pal_write && palette_index[2:0] == 3'(b)) begin
        mem[palette_index[7:3]] <= data_word;
      end
      if (rd_en) begin
        q       <= mem[rd_addr];
        q_valid <= pal_valid[{rd_addr, 3'(b)}];
      end
    end

    assign bank_rd[b] = q_valid ? q : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rd_bank <= rd_idx[2:0];
    end
  end

  assign rd_data = bank_rd[rd_bank];

  // Lowest bank wins within a row; rows are scanned upwards
  always_comb begin
    bank_hit = 1'b0;
    hit_bank = '0;
    for (int b = pcpc_pkg::BANKS - 1; b >= 0; b--) begin
      if (bank_rd[b] == key) begin
        bank_hit = 1'b1;
        hit_bank = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
      cmp_v    <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.search_start) begin
      scan_row <= '0;
      cmp_v    <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.search_step) begin
      cmp_v <= !scan_row[pcpc_pkg::ROW_W];
      if (!scan_row[pcpc_pkg::ROW_W]) begin
        scan_row <= scan_row + 6'd1;
      end
      if (cmp_v && bank_hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      key <= data_word;
      pen <= '0;
    end else if (cmd.search_step) begin
      if (!scan_row[pcpc_pkg::ROW_W]) begin
        cmp_row <= scan_row[pcpc_pkg::ROW_W-1:0];
      end
      if (cmp_v && bank_hit && !found) begin
        pen <= {cmp_row, hit_bank};
      end
    end
  end

  assign status.search_done = scan_row[pcpc_pkg::ROW_W] && !cmp_v;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_group) begin
      for (int p = 0; p < pcpc_pkg::MAX_PLANES; p++) plane_words[p] <= '0;
    end else if (cmd.load_plane) begin
      plane_words[plane_sel[2:0]] <= data_word[15:0];
    end else if (cmd.merge_pen) begin
      for (int p = 0; p < pcpc_pkg::MAX_PLANES; p++) begin
        if (4'(p) < planes && pen[p]) begin
          plane_words[p][4'd15 - pixel_sel] <= 1'b1;
        end
      end
    end
  end

  assign plane_word = plane_words[cmd.emit_pos[2:0]];

endmodule

@@ rtl/pcpc_ctrl.sv @@
// Controller state machine: input handshake, result sequencing, counters.
// Depends on pcpc_pkg.
module pcpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_valid_idx,
  input  logic [3:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [4:0]           pixels_valid,
  input  logic                 row_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          result_word,
  output logic [3:0]           position,
  output logic                 last,
  output pcpc_pkg::cmd_t       cmd,
  input  pcpc_pkg::status_t    status,
  output logic [3:0]           planes,
  output logic [3:0]           plane_sel,
  output logic [3:0]           pixel_sel,
  input  logic [31:0]          rd_data,
  input  logic [15:0]          plane_word
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_FWD    = 3'd3;
  localparam logic [2:0] S_REV    = 3'd4;

  logic [2:0] state, state_next;
  logic       to_device;
  logic [3:0] plane_count;
  logic [3:0] plane_counter;
  logic [4:0] pixel_counter;
  logic [4:0] emit_cnt;
  logic [4:0] emit_lim;
  logic       row_end_q;
  logic       accept;
  logic       out_free;
  logic [3:0] emit_idx;

  always_comb begin
    if (plane_count == 4'd0) planes = to_device ? 4'd1 : 4'd8;
    else if (plane_count > 4'd8) planes = 4'd8;
    else planes = plane_count;
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !cfg_we;
  assign accept   = in_valid && in_ready;
  assign emit_idx = emit_cnt[3:0];
  assign plane_sel = plane_counter;
  // Pen merge writes at the pixel's own column; emission walks emit_cnt
  assign pixel_sel = (state == S_SEARCH) ? pixel_counter[3:0] : emit_idx;

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.emit_pos = emit_idx;
    unique case (state)
      S_IDLE: begin
        // a register write drops any partial group
        if (cfg_we && cfg_valid_idx) cmd.clear_group = 1'b1;
        if (accept) begin
          if (action == pcpc_pkg::ACT_PAL_WRITE) begin
            cmd.pal_write = 1'b1;
          end else if (to_device) begin
            cmd.load_plane = plane_counter < 4'd8;
            if (plane_counter + 4'd1 >= planes) state_next = S_READ;
          end else begin
            cmd.search_start = 1'b1;
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_done) begin
          cmd.merge_pen = 1'b1;
          if (pixel_counter + 5'd1 >= 5'd16 || row_end_q) state_next = S_REV;
          else state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (emit_cnt >= emit_lim) begin
          cmd.clear_group = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_start = 1'b1;
          state_next = S_FWD;
        end
      end
      S_FWD: begin
        if (out_free) state_next = S_READ;
      end
      S_REV: begin
        if (out_free && emit_cnt + 5'd1 >= {1'b0, planes}) begin
          cmd.clear_group = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      to_device <= 1'b1;
      plane_count <= '0;
      plane_counter <= '0;
      pixel_counter <= '0;
      emit_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we && cfg_valid_idx) begin
        if (cfg_index == pcpc_pkg::CFG_TO_DEVICE) to_device <= cfg_data[0];
        else plane_count <= cfg_data;
        plane_counter <= '0;
        pixel_counter <= '0;
      end
      if (accept && action == pcpc_pkg::ACT_DATA && to_device) begin
        plane_counter <= plane_counter + 4'd1;
        emit_cnt <= '0;
      end
      if (state == S_SEARCH && status.search_done) begin
        pixel_counter <= pixel_counter + 5'd1;
        emit_cnt <= '0;
      end
      if (state == S_FWD && out_free) begin
        out_valid <= 1'b1;
        emit_cnt <= emit_cnt + 5'd1;
      end
      if (state == S_REV && out_free) begin
        out_valid <= 1'b1;
        emit_cnt <= emit_cnt + 5'd1;
      end
      if (cmd.clear_group) begin
        plane_counter <= '0;
        pixel_counter <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_end_q <= row_end;
      emit_lim  <= (pixels_valid > 5'd16) ? 5'd16 : pixels_valid;
    end
    if (state == S_FWD && out_free) begin
      result_word <= rd_data;
      position    <= emit_idx;
      last        <= (emit_cnt + 5'd1 == emit_lim);
    end
    if (state == S_REV && out_free) begin
      result_word <= {16'd0, plane_word};
      position    <= emit_idx;
      last        <= (emit_cnt + 5'd1 == {1'b0, planes});
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_word)))
    else $error("result dropped");
  a_planes_range: assert property (@(posedge clk) disable iff (rst)
    (planes != 4'd0) && (planes <= 4'd8)) else $error("plane count out of range");
`endif

endmodule

@@ rtl/planar_chunky_palette_converter_core.sv @@
// Top level of the planar/chunky palette converter.
// Depends on pcpc_pkg, pcpc_ctrl and pcpc_datapath.
//
// One transaction at a time. A palette write or a stored plane word is written
// when it is accepted. A completed forward group does a palette read, then
// loads the output register, for each emitted pixel, then closes the group.
// For a reverse pixel the palette sits in eight interleaved banks of 32
// entries, and the pen search reads one row of eight entries per cycle
// through every row, then does the last compare and merges the pen; a
// closing pixel then emits one plane word after another. Output stalls hold
// the emission. Reset clears the palette through per-entry valid bits at once.
module planar_chunky_palette_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  palette_index,
  input  logic [31:0] data_word,
  input  logic [4:0]  pixels_valid,
  input  logic        row_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_word,
  output logic [3:0]  position,
  output logic        last
);

  pcpc_pkg::cmd_t    cmd;
  pcpc_pkg::status_t status;
  logic [3:0]  planes;
  logic [3:0]  plane_sel;
  logic [3:0]  pixel_sel;
  logic [31:0] rd_data;
  logic [15:0] plane_word;

  pcpc_ctrl u_ctrl (
    .clk, .rst, .cfg_we,
    .cfg_index(cfg_index[0]),
    .cfg_valid_idx(1'b1),
    .cfg_data,
    .in_valid, .in_ready, .action, .pixels_valid, .row_end,
    .out_valid, .out_ready, .result_word, .position, .last,
    .cmd, .status, .planes, .plane_sel, .pixel_sel, .rd_data, .plane_word
  );

  pcpc_datapath u_dp (
    .clk, .rst, .cmd, .status, .palette_index, .data_word,
    .planes, .plane_sel, .pixel_sel, .rd_data, .plane_word
  );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for planar_chunky_palette_converter_core.
// Holds a cycle-free predictor of the palette converter, drives directed then random
// transactions under varying back-pressure; depends on pcpc_pkg and the RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic [3:0]  pos;
    logic        last;
  } conv_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = pcpc_pkg::ACT_DATA;
  logic [7:0]  palette_index = '0;
  logic [31:0] data_word = '0;
  logic [4:0]  pixels_valid = 5'd16;
  logic        row_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_word;
  logic [3:0]  position;
  logic        last;

  // predictor state
  logic [31:0] pal_mirror [pcpc_pkg::PALETTE_DEPTH];
  logic [15:0] plane_acc [pcpc_pkg::MAX_PLANES];
  int unsigned planes_seen, pixels_seen;
  logic        dir_to_device;
  logic [3:0]  planes_reg;
  conv_result_t pending_results[$];

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  planar_chunky_palette_converter_core i_dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void clear_group_state();
    foreach (plane_acc[p]) plane_acc[p] = '0;
    planes_seen = 0;
    pixels_seen = 0;
  endfunction

  function automatic int unsigned active_planes();
    int unsigned n;
    n = planes_reg;
    if (n == 0) n = dir_to_device ? 1 : 8;
    if (n > pcpc_pkg::MAX_PLANES) n = pcpc_pkg::MAX_PLANES;
    return n;
  endfunction

  // Work out the results caused by one accepted transaction.
  function automatic void predict_conversion(logic act, logic [7:0] idx, logic [31:0] word,
                                             logic [4:0] pv, logic re);
    int unsigned n, cnt, pen, bitpos;
    logic [7:0] pix_idx;
    conv_result_t r;
    n = active_planes();
    if (act == pcpc_pkg::ACT_PAL_WRITE) begin
      pal_mirror[idx] = word;
      return;
    end
    if (dir_to_device) begin
      if (planes_seen < pcpc_pkg::MAX_PLANES) plane_acc[3'(planes_seen)] = word[15:0];
      planes_seen++;
      if (planes_seen < n) return;
      cnt = (pv > pcpc_pkg::GROUP_PIXELS) ? pcpc_pkg::GROUP_PIXELS : pv;
      for (int x = 0; x < cnt; x++) begin
        pix_idx = '0;
        for (int p = 0; p < n; p++) pix_idx[p] = plane_acc[p][4'(15 - x)];
        r.word = pal_mirror[pix_idx];
        r.pos = x[3:0];
        r.last = (x + 1 == cnt);
        pending_results.push_back(r);
      end
      clear_group_state();
    end else begin
      pen = 0;
      for (int i = pcpc_pkg::PALETTE_DEPTH - 1; i >= 0; i--)
        if (pal_mirror[i] == word) pen = i;
      bitpos = 15 - (pixels_seen % 16);
      for (int p = 0; p < n; p++)
        if (pen[p]) plane_acc[p][4'(bitpos)] = 1'b1;
      pixels_seen++;
      if (pixels_seen < pcpc_pkg::GROUP_PIXELS && !re) return;
      for (int p = 0; p < n; p++) begin
        r.word = {16'h0, plane_acc[p]};
        r.pos = p[3:0];
        r.last = (p + 1 == n);
        pending_results.push_back(r);
      end
      clear_group_state();
    end
  endfunction

  always @(posedge clk) begin
    conv_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h pos %0d", result_word, position));
      end else begin
        exp_r = pending_results.pop_front();
        if (result_word !== exp_r.word || position !== exp_r.pos || last !== exp_r.last)
          flag_mismatch($sformatf("got %h/%0d/%b expected %h/%0d/%b", result_word, position,
                                  last, exp_r.word, exp_r.pos, exp_r.last));
      end
    end
  end

  task automatic send_item(logic act, logic [7:0] idx, logic [31:0] word, logic [4:0] pv,
                           logic re);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    palette_index <= idx;
    data_word <= word;
    pixels_valid <= pv;
    row_end <= re;
    do @(posedge clk); while (!in_ready);
    predict_conversion(act, idx, word, pv, re);
  endtask

  // Hold off until all results are in and the block is idle again.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pcpc_pkg::CFG_TO_DEVICE) dir_to_device = val[0];
    else planes_reg = val;
    clear_group_state();
  endtask

  task automatic test_forward_directed();
    write_reg(pcpc_pkg::CFG_TO_DEVICE, 4'd1);
    write_reg(pcpc_pkg::CFG_PLANE_COUNT, 4'd0);
    send_item(pcpc_pkg::ACT_PAL_WRITE, 8'd1, 32'hFFFF_FFFF, 5'd0, 1'b0);
    send_item(pcpc_pkg::ACT_PAL_WRITE, 8'd255, 32'h1234_5678, 5'd31, 1'b1);
    send_item(pcpc_pkg::ACT_DATA, 8'hFF, 32'hFFFF_A5A5, 5'd16, 1'b1);
    send_item(pcpc_pkg::ACT_DATA, 8'h00, 32'h0000_FFFF, 5'd0, 1'b0);   // nothing emitted
    send_item(pcpc_pkg::ACT_DATA, 8'h00, 32'h0000_8001, 5'd31, 1'b0);  // saturates to sixteen
    send_item(pcpc_pkg::ACT_DATA, 8'h00, 32'h0000_F000, 5'd1, 1'b0);
    write_reg(pcpc_pkg::CFG_PLANE_COUNT, 4'd8);
    for (int p = 0; p < 8; p++)
      send_item(pcpc_pkg::ACT_DATA, 8'h0, 32'h0000_FFFF, 5'd16, 1'b0);
    write_reg(pcpc_pkg::CFG_PLANE_COUNT, 4'd15);                      // saturates to eight
    for (int p = 0; p < 8; p++)
      send_item(pcpc_pkg::ACT_DATA, 8'h0, 32'h0000_00FF, 5'd5, 1'b0);
  endtask

  task automatic test_reverse_directed();
    write_reg(pcpc_pkg::CFG_TO_DEVICE, 4'd0);
    write_reg(pcpc_pkg::CFG_PLANE_COUNT, 4'd0);
    // duplicate: first wins
    send_item(pcpc_pkg::ACT_PAL_WRITE, 8'd7, 32'hFFFF_FFFF, 5'd0, 1'b0);
    send_item(pcpc_pkg::ACT_DATA, 8'h0, 32'hFFFF_FFFF, 5'd0, 1'b0);
    send_item(pcpc_pkg::ACT_DATA, 8'h0, 32'hDEAD_BEEF, 5'd0, 1'b0);        // no match
    send_item(pcpc_pkg::ACT_DATA, 8'h0, 32'h1234_5678, 5'd0, 1'b1);        // row end
    for (int x = 0; x < 16; x++)
      send_item(pcpc_pkg::ACT_DATA, 8'h0, (x % 2) ? 32'h1234_5678 : 32'h0, 5'd31, 1'b0);
    write_reg(pcpc_pkg::CFG_PLANE_COUNT, 4'd2);          // pen bits above plane two drop
    send_item(pcpc_pkg::ACT_DATA, 8'h0, 32'h1234_5678, 5'd0, 1'b1);
    write_reg(pcpc_pkg::CFG_PLANE_COUNT, 4'd1);
    send_item(pcpc_pkg::ACT_DATA, 8'h0, 32'hFFFF_FFFF, 5'd0, 1'b0);
    // partial group discarded by a register write
    write_reg(pcpc_pkg::CFG_PLANE_COUNT, 4'd3);
    send_item(pcpc_pkg::ACT_DATA, 8'h0, 32'h1234_5678, 5'd0, 1'b1);
  endtask

  task automatic test_random();
    int unsigned pick;
    logic [31:0] word;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      write_reg(pcpc_pkg::CFG_TO_DEVICE, ph[0] ? 4'd1 : {3'($urandom), 1'b0});
      write_reg(pcpc_pkg::CFG_PLANE_COUNT, (ph == 2) ? 4'd15 : 4'($urandom_range(15)));
      for (int k = 0; k < 13; k++) begin
        if (ph == 4 && k == 6) drain();
        pick = $urandom_range(99);
        word = $urandom;
        if (!dir_to_device && pick < 75) word = pal_mirror[8'($urandom_range(255))];
        if (pick >= 85)
          send_item(pcpc_pkg::ACT_PAL_WRITE, 8'($urandom), $urandom, 5'($urandom),
                    1'($urandom));
        else
          send_item(pcpc_pkg::ACT_DATA, 8'($urandom), word,
                    ($urandom_range(3) == 0) ? 5'($urandom) : 5'd16,
                    ($urandom_range(9) == 0));
      end
    end
  endtask

  initial begin
    foreach (pal_mirror[i]) pal_mirror[i] = '0;
    clear_group_state();
    dir_to_device = 1'b1;
    planes_reg = 4'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_forward_directed();
    test_reverse_directed();
    test_random();
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end

endmodule
